// ===== hdl/shbg_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample history bar graph package
// Shared constants, payload types, controller interface types and the
// column byte function used by the bar graph datapath.
// ----------------------------------------------------------------------------
package shbg_pkg;

    // Number of stored columns and the widths that follow from it.
    localparam int HISTORY_LENGTH = 128;
    localparam int PTR_W          = $clog2(HISTORY_LENGTH);
    localparam int EMPTY_W        = $clog2(HISTORY_LENGTH + 1);
    localparam int HIST_W         = 4;

    // Width of one character in columns, and the widest draw in characters.
    localparam int COLS_PER_CHAR  = 8;
    localparam int HIST_CHARS     = HISTORY_LENGTH / COLS_PER_CHAR;
    localparam int MAX_CHARS      = (HIST_CHARS < 16) ? HIST_CHARS : 16;

    localparam int CHARS_W        = 5;
    localparam int INDEX_W        = 4;
    localparam int COL_W          = $clog2(COLS_PER_CHAR);

    // Transaction kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         sample;
        logic [CHARS_W-1:0] char_count;
        logic               large_mode;
    } item_t;

    typedef struct packed {
        logic [63:0]        top_bytes;
        logic [63:0]        bottom_bytes;
        logic [INDEX_W-1:0] char_index;
        logic               last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;
        logic start;
        logic issue;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_draw;
        logic draw_empty;
        logic group_end;
        logic char_last;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [7:0] top;
        logic [7:0] bot;
    } col_bytes_t;

    // Top and bottom page bytes of one column.
    function automatic col_bytes_t column_bytes(
        input logic [HIST_W-1:0] nibble,
        input logic              tall,
        input logic              empty
    );
        col_bytes_t        res;
        logic [HIST_W-1:0] v;
        logic [2:0]        opp;
        logic [7:0]        stack;
        v     = tall ? nibble : (nibble >> 1);
        opp   = 3'd7 - v[2:0];
        stack = 8'hFF >> opp;
        stack = stack << opp;
        if (empty) begin
            res.top = 8'h00;
            res.bot = 8'h00;
        end
        else if (!tall || v[3]) begin
            res.top = stack;
            res.bot = 8'hFF;
        end
        else begin
            res.top = 8'h00;
            res.bot = stack;
        end
        return res;
    endfunction

endpackage

// ===== hdl/shbg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module shbg_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/shbg_datapath.sv =====
// ----------------------------------------------------------------------------
// Bar graph datapath
// History RAM with its write pointer, fill count, column walk counters,
// character assembly registers and the result output register.
// ----------------------------------------------------------------------------
module shbg_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  shbg_pkg::item_t  item,
    input  shbg_pkg::cmd_t   cmd,
    output shbg_pkg::sts_t   sts,
    output logic             result_valid,
    input  logic             result_stall,
    output shbg_pkg::result_t result
);

    localparam logic [shbg_pkg::PTR_W-1:0] LAST_ADDR =
        shbg_pkg::PTR_W'(shbg_pkg::HISTORY_LENGTH - 1);
    localparam logic [shbg_pkg::COL_W-1:0] LAST_COL =
        shbg_pkg::COL_W'(shbg_pkg::COLS_PER_CHAR - 1);

    logic [shbg_pkg::PTR_W-1:0]   wptr_reg, wptr_next;
    logic [shbg_pkg::EMPTY_W-1:0] empty_reg, empty_next;
    logic                         large_reg, large_next;
    logic [shbg_pkg::CHARS_W-1:0] chars_reg, chars_next;
    logic [shbg_pkg::INDEX_W-1:0] char_reg, char_next;
    logic [shbg_pkg::COL_W-1:0]   j_reg, j_next;
    logic [shbg_pkg::PTR_W-1:0]   col_reg, col_next;
    logic [shbg_pkg::PTR_W-1:0]   addr_reg, addr_next;
    logic                         empty_d_reg, empty_d_next;
    logic                         shift_d_reg, shift_d_next;
    logic [55:0]                  asm_top_reg, asm_top_next;
    logic [55:0]                  asm_bot_reg, asm_bot_next;
    logic                         out_valid_reg, out_valid_next;
    shbg_pkg::result_t            out_reg, out_next;

    logic [shbg_pkg::CHARS_W-1:0]   sat_chars;
    logic [shbg_pkg::PTR_W:0]       start_wide;
    logic [shbg_pkg::PTR_W-1:0]     start_col;
    logic [shbg_pkg::PTR_W:0]       addr_sum;
    logic [shbg_pkg::PTR_W-1:0]     start_addr;
    logic [shbg_pkg::CHARS_W-1:0]   chars_m1;
    logic [shbg_pkg::HIST_W-1:0]    rd_data;
    shbg_pkg::col_bytes_t           cb;

    shbg_ram #(
        .WIDTH (shbg_pkg::HIST_W),
        .DEPTH (shbg_pkg::HISTORY_LENGTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wptr_reg),
        .wr_data (item.sample[7:4]),
        .rd_en   (cmd.issue),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Draw setup: the rightmost columns map onto the ring from the oldest entry.
    always_comb
    begin
        sat_chars  = (item.char_count > shbg_pkg::CHARS_W'(shbg_pkg::MAX_CHARS)) ?
                     shbg_pkg::CHARS_W'(shbg_pkg::MAX_CHARS) : item.char_count;
        start_wide = (shbg_pkg::PTR_W+1)'(shbg_pkg::HISTORY_LENGTH) -
                     (shbg_pkg::PTR_W+1)'({sat_chars, 3'b000});
        start_col  = start_wide[shbg_pkg::PTR_W-1:0];
        addr_sum   = {1'b0, wptr_reg} + {1'b0, start_col};
        if (addr_sum >= (shbg_pkg::PTR_W+1)'(shbg_pkg::HISTORY_LENGTH))
        begin
            addr_sum = addr_sum - (shbg_pkg::PTR_W+1)'(shbg_pkg::HISTORY_LENGTH);
        end
        start_addr = addr_sum[shbg_pkg::PTR_W-1:0];
    end

    assign cb       = shbg_pkg::column_bytes(rd_data, large_reg, empty_d_reg);
    assign chars_m1 = chars_reg - shbg_pkg::CHARS_W'(1);

    always_comb
    begin
        sts.is_draw    = (item.kind == shbg_pkg::KIND_DRAW);
        sts.draw_empty = (sat_chars == '0);
        sts.group_end  = (j_reg == LAST_COL);
        sts.char_last  = (char_reg == chars_m1[shbg_pkg::INDEX_W-1:0]);
        sts.out_free   = !out_valid_reg || !result_stall;
    end

    always_comb
    begin
        wptr_next      = wptr_reg;
        empty_next     = empty_reg;
        large_next     = large_reg;
        chars_next     = chars_reg;
        char_next      = char_reg;
        j_next         = j_reg;
        col_next       = col_reg;
        addr_next      = addr_reg;
        empty_d_next   = empty_d_reg;
        shift_d_next   = 1'b0;
        asm_top_next   = asm_top_reg;
        asm_bot_next   = asm_bot_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;

        if (cmd.push)
        begin
            wptr_next = (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + 1'b1;
            if (empty_reg != '0)
            begin
                empty_next = empty_reg - 1'b1;
            end
        end

        if (cmd.start)
        begin
            large_next = item.large_mode;
            chars_next = sat_chars;
            char_next  = '0;
            j_next     = '0;
            col_next   = start_col;
            addr_next  = start_addr;
        end

        // The final column of a character is not shifted; it joins at emit.
        if (shift_d_reg)
        begin
            asm_top_next = {cb.top, asm_top_reg[55:8]};
            asm_bot_next = {cb.bot, asm_bot_reg[55:8]};
        end

        if (cmd.issue)
        begin
            j_next       = j_reg + 1'b1;
            col_next     = col_reg + 1'b1;
            addr_next    = (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;
            empty_d_next = (shbg_pkg::EMPTY_W'(col_reg) < empty_reg);
            shift_d_next = (j_reg != LAST_COL);
        end

        if (cmd.emit)
        begin
            out_valid_next        = 1'b1;
            out_next.top_bytes    = {cb.top, asm_top_reg};
            out_next.bottom_bytes = {cb.bot, asm_bot_reg};
            out_next.char_index   = char_reg;
            out_next.last         = sts.char_last;
            char_next             = char_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            empty_reg     <= shbg_pkg::EMPTY_W'(shbg_pkg::HISTORY_LENGTH);
            chars_reg     <= '0;
            char_reg      <= '0;
            j_reg         <= '0;
            col_reg       <= '0;
            addr_reg      <= '0;
            shift_d_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg      <= wptr_next;
            empty_reg     <= empty_next;
            chars_reg     <= chars_next;
            char_reg      <= char_next;
            j_reg         <= j_next;
            col_reg       <= col_next;
            addr_reg      <= addr_next;
            shift_d_reg   <= shift_d_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        large_reg   <= large_next;
        empty_d_reg <= empty_d_next;
        asm_top_reg <= asm_top_next;
        asm_bot_reg <= asm_bot_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hdl/shbg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bar graph controller
// Sequences pushes, the column walk of a draw and the hand-off of each
// finished character to the output register.
// ----------------------------------------------------------------------------
module shbg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  shbg_pkg::sts_t sts,
    output shbg_pkg::cmd_t cmd
);

    shbg_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shbg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_stall = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            shbg_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if (!sts.is_draw)
                    begin
                        cmd.push = 1'b1;
                    end
                    else if (!sts.draw_empty)
                    begin
                        cmd.start  = 1'b1;
                        state_next = shbg_pkg::ST_READ;
                    end
                end
            end
            shbg_pkg::ST_READ:
            begin
                cmd.issue = 1'b1;
                if (sts.group_end)
                begin
                    state_next = shbg_pkg::ST_FINISH;
                end
            end
            shbg_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.char_last)
                    begin
                        state_next = shbg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.issue  = 1'b1;
                        state_next = shbg_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = shbg_pkg::ST_IDLE;
            end
        endcase
    end

    // A character is handed over only when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("character emitted into an occupied output register");

    // The finish state is reached only after the eighth column read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shbg_pkg::ST_FINISH && $past(state_reg) == shbg_pkg::ST_READ)
        |-> $past(sts.group_end))
        else $error("character finished before all its columns were read");

    // A held output keeps the controller waiting in the finish state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shbg_pkg::ST_FINISH && !sts.out_free)
        |=> state_reg == shbg_pkg::ST_FINISH)
        else $error("finish state left while the output was stalled");

    // A draw starts, or a sample is pushed, only from an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start || cmd.push) |-> (item_valid && !item_stall))
        else $error("datapath command without an accepted transaction");

endmodule

// ===== hdl/sample_history_bar_graph.sv =====
// ----------------------------------------------------------------------------
// Sample history bar graph
// Keeps the upper nibbles of the last samples and renders the newest columns
// as eight-column characters of top and bottom page bytes.
// ----------------------------------------------------------------------------
// Usage: the item channel (item_valid, item_stall, item) carries two kinds of
// transaction. A push stores the upper nibble of item.sample as the newest
// column; it produces no result. A draw renders the rightmost char_count * 8
// columns (char_count saturated at 16 and at the history length / 8), oldest
// first, and produces one result transaction per character on the result
// channel (result_valid, result_stall, result). A draw with a width of zero
// produces nothing. Flow: the history lives in a RAM with one read port, read
// one column per cycle except while the walk waits at a character boundary,
// and the item channel stalls until the last character of a draw has been
// handed to the output register. While the receiver stalls, the finished
// result waits in the output register and the walk pauses at the next
// character boundary; the last result may still wait while new items are
// accepted. Reset empties the history: every column reads as empty until a
// sample has been pushed into it, and no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module sample_history_bar_graph (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  shbg_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output shbg_pkg::result_t result
);

    // Command and status buses between the controller and the datapath.
    shbg_pkg::cmd_t cmd;
    shbg_pkg::sts_t sts;

    // The controller accepts transactions only when idle and steps the
    // column walk of a draw.
    shbg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath holds the history ring, the column counters, the character
    // assembly and the output register.
    shbg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== tb/sv/bar_graph_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar graph checker
// Watches the item and result channels of the sample history bar graph,
// keeps its own copy of the sample history, predicts the characters that each
// draw renders and compares every result transaction with the oldest
// prediction.
// ----------------------------------------------------------------------------
module bar_graph_checker
    import shbg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      fail_count,
    output int      chars_outstanding
);

    logic [3:0] sample_hist [HISTORY_LENGTH];
    int         unfilled_cols;
    result_t    expected_chars [$];

    // Top page byte in bits 15:8, bottom page byte in bits 7:0.
    function automatic logic [15:0] column_pages(input int col, input logic tall);
        logic [3:0] level;
        logic [7:0] bar;
        if (col < unfilled_cols) begin
            return 16'h0000;
        end
        level = tall ? sample_hist[col] : {1'b0, sample_hist[col][3:1]};
        // The bar fills from the top bit down, one bit more than the low level bits.
        bar = ~(8'hFF >> (int'(level[2:0]) + 1));
        if (!tall || level[3]) begin
            return {bar, 8'hFF};
        end
        return {8'h00, bar};
    endfunction

    task automatic apply_item(input item_t it);
        int         width;
        int         char_limit;
        int         first_col;
        logic [15:0] pages;
        result_t    ch;
        if (it.kind == KIND_PUSH) begin
            for (int i = 0; i < HISTORY_LENGTH - 1; i++) begin
                sample_hist[i] = sample_hist[i + 1];
            end
            sample_hist[HISTORY_LENGTH - 1] = it.sample[7:4];
            if (unfilled_cols > 0) begin
                unfilled_cols--;
            end
        end
        else begin
            char_limit = HISTORY_LENGTH / 8;
            if (char_limit > 16) begin
                char_limit = 16;
            end
            width = int'(it.char_count);
            if (width > char_limit) begin
                width = char_limit;
            end
            first_col = HISTORY_LENGTH - width * 8;
            for (int c = 0; c < width; c++) begin
                ch = '0;
                for (int j = 0; j < 8; j++) begin
                    pages = column_pages(first_col + c * 8 + j, it.large_mode);
                    ch.top_bytes[8 * j +: 8]    = pages[15:8];
                    ch.bottom_bytes[8 * j +: 8] = pages[7:0];
                end
                ch.char_index = c[3:0];
                ch.last       = (c == width - 1);
                expected_chars.push_back(ch);
            end
        end
    endtask

    task automatic compare_char(input result_t got);
        result_t want;
        bit      bad;
        bad = 0;
        if (expected_chars.size() == 0) begin
            $error("unexpected result transaction: top_bytes %h bottom_bytes %h",
                   got.top_bytes, got.bottom_bytes);
            fail_count++;
            return;
        end
        want = expected_chars.pop_front();
        if (got.top_bytes !== want.top_bytes) begin
            $error("top_bytes: expected %h, actual %h", want.top_bytes, got.top_bytes);
            bad = 1;
        end
        if (got.bottom_bytes !== want.bottom_bytes) begin
            $error("bottom_bytes: expected %h, actual %h",
                   want.bottom_bytes, got.bottom_bytes);
            bad = 1;
        end
        if (got.char_index !== want.char_index) begin
            $error("char_index: expected %0d, actual %0d", want.char_index, got.char_index);
            bad = 1;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            bad = 1;
        end
        if (bad) begin
            fail_count++;
        end
    endtask

    initial begin
        fail_count        = 0;
        chars_outstanding = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < HISTORY_LENGTH; i++) begin
                sample_hist[i] = 4'h0;
            end
            unfilled_cols = HISTORY_LENGTH;
            expected_chars.delete();
        end
        else begin
            // The result is compared before the item is applied, so a result
            // of an earlier draw never meets a prediction of a later one.
            if (result_valid && !result_stall) begin
                compare_char(result);
            end
            if (item_valid && !item_stall) begin
                apply_item(item);
            end
        end
        chars_outstanding = expected_chars.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample history bar graph testbench
// Drives pushes and draws into the bar graph under several idling patterns,
// including a long receiver hold-off, and lets the checker judge every
// rendered character.
// ----------------------------------------------------------------------------
module tb;

    import shbg_pkg::*;

    // Generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 400000;
    // Quiet cycles after the last expected character, to catch stragglers.
    localparam int SETTLE_CYCLES = 40;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 600;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int fail_count;
    int chars_outstanding;
    int cycle_count = 0;

    // Idling percentages, changed between phases by the stimulus process.
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;

    // The stimulus process arms the long hold-off; the receiver process
    // counts it down on its own and marks it done.
    bit hold_armed = 0;
    bit hold_done  = 0;
    int hold_count = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sample_history_bar_graph i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    bar_graph_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result),
        .fail_count        (fail_count),
        .chars_outstanding (chars_outstanding)
    );

    // Watchdog: a run that hangs ends here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stalls at random at the current percentage, or holds off
    // for a long stretch once that has been armed.
    initial begin
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_armed && !hold_done) begin
                result_stall <= 1'b1;
                hold_count++;
                if (hold_count == HOLD_CYCLES) begin
                    hold_done = 1;
                end
            end
            else begin
                result_stall <= ($urandom_range(99) < rcv_stall_pct);
            end
        end
    end

    function automatic item_t make_push(input logic [7:0] value);
        item_t it;
        it            = '0;
        it.kind       = KIND_PUSH;
        it.sample     = value;
        it.char_count = 5'($urandom_range(31));
        it.large_mode = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic item_t make_draw(input int width, input logic tall);
        item_t it;
        it            = '0;
        it.kind       = KIND_DRAW;
        it.sample     = 8'($urandom_range(255));
        it.char_count = 5'(width);
        it.large_mode = tall;
        return it;
    endfunction

    // Mostly pushes, so the history fills, and mostly narrow draws, so the
    // run stays short; a few draws are wider, up to full width, or oversized.
    function automatic item_t random_item();
        int pick;
        int width;
        if ($urandom_range(99) < 55) begin
            return make_push(8'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            width = 0;
        end
        else if (pick < 80) begin
            width = $urandom_range(4, 1);
        end
        else if (pick < 90) begin
            width = $urandom_range(16, 5);
        end
        else begin
            width = $urandom_range(31, 17);
        end
        return make_draw(width, 1'($urandom_range(1)));
    endfunction

    // Offers one transaction after a random gap and returns at the rising
    // edge where it is accepted. Valid stays high between back-to-back items.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) begin
            @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted character has come out.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        wait (chars_outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int snd_pct, input int rcv_pct);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        repeat (count) send_item(random_item());
    endtask

    initial begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A full-width draw right after reset sees only empty
        // columns, and a zero-width draw gives nothing.
        send_item(make_draw(16, 1'b1));
        send_item(make_draw(0, 1'b0));
        // Every nibble level, with the sample extremes 0x00 and 0xFF among them.
        for (int k = 0; k < 16; k++) begin
            send_item(make_push({4'(k), (k % 2 == 1) ? 4'hF : 4'h0}));
        end
        send_item(make_draw(2, 1'b1));
        send_item(make_draw(2, 1'b0));
        // Oversized widths saturate at the full history.
        send_item(make_draw(31, 1'b1));
        send_item(make_draw(17, 1'b0));
        send_item(make_draw(1, 1'b1));
        drain();

        // Long receiver hold-off while the sender keeps offering pushes and draws, so
        // the block backs up and stalls its item channel.
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_armed    = 1;
        for (int n = 0; n < 15; n++) begin
            if (n % 3 == 0) begin
                send_item(make_push(8'($urandom_range(255))));
            end
            else begin
                send_item(make_draw($urandom_range(3, 1), 1'($urandom_range(1))));
            end
        end
        drain();

        run_phase(60, 0, 0);
        run_phase(60, 66, 0);
        drain();
        run_phase(60, 0, 66);
        run_phase(60, 37, 37);
        drain();

        if (fail_count == 0 && chars_outstanding == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/shbg_pkg.sv
hdl/shbg_ram.sv
hdl/shbg_datapath.sv
hdl/shbg_ctrl.sv
hdl/sample_history_bar_graph.sv
tb/sv/bar_graph_checker.sv
tb/sv/tb.sv
